// ===== sv/sfwm_pkg.sv =====
`default_nettype none

package sfwm_pkg;

    // Panel and frame memory geometry.
    localparam int VISIBLE_LINES   = 240;
    localparam int TOTAL_LINES     = 320;
    localparam int DISPLAY_COLUMNS = 240;

    // Frame memory line numbers need nine bits; sums of two line numbers need ten.
    localparam int LINE_W = 9;
    localparam int SUM_W  = LINE_W + 1;

    localparam logic [7:0]        COL_LAST  = 8'(DISPLAY_COLUMNS - 1);
    localparam logic [7:0]        VIS_LAST  = 8'(VISIBLE_LINES - 1);
    localparam logic [SUM_W-1:0]  TOTAL_S   = SUM_W'(TOTAL_LINES);
    localparam logic [SUM_W-1:0]  VIS_MOD_S = SUM_W'(VISIBLE_LINES % TOTAL_LINES);
    localparam logic [SUM_W-1:0]  DOWN_STEP = SUM_W'(TOTAL_LINES - (VISIBLE_LINES % TOTAL_LINES));

    // Item kinds on the input channel.
    typedef enum logic {
        FUNC_FLUSH   = 1'b0,
        FUNC_SET_DIR = 1'b1
    } func_t;

    // Scroll directions.
    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4
    } dir_t;

    // One frame memory write.
    typedef struct packed {
        logic [7:0]        draw_x;
        logic [LINE_W-1:0] draw_y;
        logic [7:0]        draw_width;
        logic [7:0]        draw_height;
        logic [15:0]       buffer_offset;
        logic [LINE_W-1:0] scroll_start;
        logic              scroll_written;
        dir_t              direction_now;
        logic              last;
    } result_t;

    // All writes produced by one flush.
    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } flush_out_t;

    // Reduce a sum below twice the frame height into the ring.
    function automatic logic [LINE_W-1:0] ring_wrap(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] r;
        begin
            r = (v >= TOTAL_S) ? (v - TOTAL_S) : v;
            return r[LINE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/sfwm_map.sv =====
`default_nettype none

module sfwm_map
    import sfwm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire func_t      func,
    input  wire logic [2:0] new_direction,
    input  wire logic [7:0] area_left,
    input  wire logic [7:0] area_right,
    input  wire logic [7:0] area_top,
    input  wire logic [7:0] area_bottom,
    output flush_out_t      flush_out
);

    dir_t              dir_reg, dir_next;
    logic [LINE_W-1:0] wo_reg, wo_next;
    logic [LINE_W-1:0] so_reg, so_next;

    logic [7:0]        left_s, right_s, top_s, bottom_s, left_c, right_c, top_c, bottom_c;
    logic [7:0]        width, height;
    logic [LINE_W-1:0] y1, y2, h1_full;
    logic [LINE_W-1:0] to_scroll, ts_mod;
    logic              sw;
    logic [15:0]       wrap_offset;

    // Saturate the rectangle to the panel and fix reversed edges.
    always_comb begin
        left_s   = (area_left   > COL_LAST) ? COL_LAST : area_left;
        right_s  = (area_right  > COL_LAST) ? COL_LAST : area_right;
        top_s    = (area_top    > VIS_LAST) ? VIS_LAST : area_top;
        bottom_s = (area_bottom > VIS_LAST) ? VIS_LAST : area_bottom;
        left_c   = left_s;
        right_c  = (right_s < left_s) ? left_s : right_s;
        top_c    = top_s;
        bottom_c = (bottom_s < top_s) ? top_s : bottom_s;
        width    = 8'(right_c - left_c + 8'd1);
        height   = 8'(bottom_c - top_c + 8'd1);
    end

    // Offsets, direction and the one or two writes of a flush.
    always_comb begin
        dir_next  = dir_reg;
        wo_next   = wo_reg;
        so_next   = so_reg;
        sw        = 1'b0;
        to_scroll = LINE_W'(height);
        ts_mod    = '0;

        if (func == FUNC_SET_DIR) begin
            case (new_direction)
                DIR_NONE, DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT:
                    dir_next = dir_t'(new_direction);
                default: dir_next = DIR_NONE;
            endcase
        end else begin
            // A new screen page begins when the rectangle reaches the entry edge.
            if (dir_reg == DIR_DOWN && bottom_c == VIS_LAST) begin
                wo_next = ring_wrap(SUM_W'(wo_reg) + DOWN_STEP);
            end else if (dir_reg == DIR_UP && top_c == 8'd0) begin
                wo_next = ring_wrap(SUM_W'(wo_reg) + VIS_MOD_S);
            end

            case (dir_reg)
                DIR_DOWN: begin
                    if (bottom_c != VIS_LAST) begin
                        if (top_c == 8'd0) begin
                            to_scroll = {height, 1'b0};
                            dir_next  = DIR_NONE;
                        end
                        sw = 1'b1;
                    end
                end
                DIR_UP: begin
                    if (top_c != 8'd0) begin
                        if (bottom_c == VIS_LAST) begin
                            to_scroll = {height, 1'b0};
                            dir_next  = DIR_NONE;
                        end
                        sw = 1'b1;
                    end
                end
                DIR_LEFT: begin
                    if (right_c == COL_LAST) dir_next = DIR_NONE;
                end
                DIR_RIGHT: begin
                    if (left_c == 8'd0) dir_next = DIR_NONE;
                end
                default: ;
            endcase

            ts_mod = ring_wrap(SUM_W'(to_scroll));
            if (sw) begin
                if (dir_reg == DIR_DOWN) begin
                    so_next = ring_wrap(SUM_W'(so_reg) + TOTAL_S - SUM_W'(ts_mod));
                end else begin
                    so_next = ring_wrap(SUM_W'(so_reg) + SUM_W'(ts_mod));
                end
            end
        end
    end

    // Frame memory lines of the rectangle's edges and the wrap split.
    always_comb begin
        y1          = ring_wrap(SUM_W'(top_c) + SUM_W'(wo_next));
        y2          = ring_wrap(SUM_W'(bottom_c) + SUM_W'(wo_next));
        h1_full     = LINE_W'(TOTAL_S - SUM_W'(y1));
        wrap_offset = 16'(width) * 16'(h1_full[7:0]);

        flush_out.two                  = (y2 < y1);

        flush_out.first.draw_x         = left_c;
        flush_out.first.draw_y         = y1;
        flush_out.first.draw_width     = width;
        flush_out.first.draw_height    = flush_out.two ? h1_full[7:0] : height;
        flush_out.first.buffer_offset  = 16'd0;
        flush_out.first.scroll_start   = so_next;
        flush_out.first.scroll_written = sw;
        flush_out.first.direction_now  = dir_next;
        flush_out.first.last           = !flush_out.two;

        flush_out.second.draw_x         = left_c;
        flush_out.second.draw_y         = '0;
        flush_out.second.draw_width     = width;
        flush_out.second.draw_height    = 8'(y2 + 9'd1);
        flush_out.second.buffer_offset  = wrap_offset;
        flush_out.second.scroll_start   = so_next;
        flush_out.second.scroll_written = sw;
        flush_out.second.direction_now  = dir_next;
        flush_out.second.last           = 1'b1;
    end

    // Scroll state advances once per consumed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg <= DIR_NONE;
            wo_reg  <= '0;
            so_reg  <= '0;
        end else if (step) begin
            dir_reg <= dir_next;
            wo_reg  <= wo_next;
            so_reg  <= so_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sfwm_outq.sv =====
`default_nettype none

module sfwm_outq
    import sfwm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire flush_out_t flush_in,
    output logic            can_load,
    output logic            out_valid,
    input  wire logic       out_ready,
    output result_t         out_item
);

    result_t    head_reg, tail_reg;
    logic [1:0] cnt_reg, cnt_next;

    // A flush may load once the queue is empty or its last item leaves now.
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = head_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = flush_in.two ? 2'd2 : 2'd1;
        end else if (out_valid && out_ready) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Item payload: the head shows, the tail moves up when the head is taken.
    always_ff @(posedge aclk) begin
        if (load) begin
            head_reg <= flush_in.first;
            tail_reg <= flush_in.second;
        end else if (out_valid && out_ready) begin
            head_reg <= tail_reg;
        end
    end

endmodule

`default_nettype wire

// ===== sv/scrolling_frame_window_mapper_core.sv =====
`default_nettype none

// Scrolling frame window mapper. Each input item either sets the scroll
// direction (tuser high, no output) or flushes an update rectangle (tuser low),
// which yields one frame memory write, or two when the rectangle wraps past the
// last frame line; tlast marks the final write of a flush. An input item is
// registered, mapped combinationally against the scroll state and placed in a
// two-entry output queue. Direction items flow at one per cycle; flushes
// sustain one per cycle when unwrapped and the output is ready, while a wrapped
// flush holds the input until its second write is taken, the output port being
// the limit.
module scrolling_frame_window_mapper_core
    import sfwm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // new_direction[2:0], area_left[10:3], area_right[18:11],
    // area_top[26:19], area_bottom[34:27], zero[39:35]
    input  wire logic [39:0] s_tdata,
    // func[0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // draw_x[7:0], draw_y[16:8], draw_width[24:17], draw_height[32:25],
    // buffer_offset[48:33], scroll_start[57:49], scroll_written[58],
    // direction_now[61:59], zero[63:62]
    output logic [63:0]      m_tdata,
    output logic             m_tlast
);

    logic        in_valid_reg;
    logic [34:0] in_data_reg;
    func_t       in_func_reg;
    logic        step, q_can_load;
    flush_out_t  flush_out;
    result_t     head;

    // Input register consumes when the mapper can place its result.
    assign step     = in_valid_reg && (in_func_reg == FUNC_SET_DIR || q_can_load);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[34:0];
            in_func_reg <= func_t'(s_tuser);
        end
    end

    sfwm_map u_map (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .func          (in_func_reg),
        .new_direction (in_data_reg[2:0]),
        .area_left     (in_data_reg[10:3]),
        .area_right    (in_data_reg[18:11]),
        .area_top      (in_data_reg[26:19]),
        .area_bottom   (in_data_reg[34:27]),
        .flush_out     (flush_out)
    );

    sfwm_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step && in_func_reg == FUNC_FLUSH),
        .flush_in  (flush_out),
        .can_load  (q_can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (head)
    );

    // Pack the head write onto the result channel.
    assign m_tdata = {2'b00, head.direction_now, head.scroll_written, head.scroll_start,
                      head.buffer_offset, head.draw_height, head.draw_width,
                      head.draw_y, head.draw_x};
    assign m_tlast = head.last;

endmodule

`default_nettype wire

// ===== sv/sfwm_checker.sv =====
`default_nettype none

module sfwm_checker
    import sfwm_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tlast
);

    // A stalled item holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // Nothing is shown in the cycle after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The second write of a wrapped flush follows at once.
    a_second: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("second write of a wrapped flush missing");

    // The first write of a wrapped flush ends on the last frame line.
    a_wrap_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |->
            (10'(m_tdata[16:8]) + 10'(m_tdata[32:25])) == TOTAL_S)
        else $error("wrapped write does not end at the ring end");

    // Every write covers at least one column and one line.
    a_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[24:17] != 8'd0 && m_tdata[32:25] != 8'd0)
        else $error("empty frame memory write");

endmodule

bind scrolling_frame_window_mapper_core sfwm_checker u_sfwm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
